### rtl/core/pcfd_pkg.sv
package pcfd_pkg;

  // Field and register widths.
  localparam int unsigned DataW = 32;
  localparam int unsigned SmpW  = 16;
  localparam int unsigned ErrW  = SmpW + 1;
  localparam int unsigned ESumW = SmpW + 2;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned DProdW = DataW + ErrW;

  // Limits of the 32-bit signed range.
  localparam logic signed [DataW-1:0] DataMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] DataMin = 32'sh8000_0000;

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    RegPropGain  = 3'd0,
    RegIntegGain = 3'd1,
    RegDerivGain = 3'd2,
    RegDerivPole = 3'd3,
    RegOutMin    = 3'd4,
    RegOutMax    = 3'd5,
    RegIntegMin  = 3'd6,
    RegIntegMax  = 3'd7
  } reg_idx_e;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [DataW-1:0] deriv_gain;
    logic signed [DataW-1:0] deriv_pole;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
    logic signed [DataW-1:0] integ_min;
    logic signed [DataW-1:0] integ_max;
  } cfg_t;

  // Products handed from the multiply stage to the state-update stage.
  typedef struct packed {
    logic signed [DataW-1:0]  prop;
    logic signed [DataW-1:0]  iterm;
    logic signed [DProdW-1:0] dprod;
  } prod_t;

  // Terms handed from the state-update stage to the output stage.
  typedef struct packed {
    logic signed [DataW-1:0] prop;
    logic signed [DataW-1:0] integ;
    logic signed [DataW-1:0] deriv;
  } terms_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [DataW-1:0] sat32_f(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7fff_ffff;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      sat32_f = DataMax;
    end else if (v < lo) begin
      sat32_f = DataMin;
    end else begin
      sat32_f = v[DataW-1:0];
    end
  endfunction

  // Clamp with the upper test first, so crossed limits resolve to the upper one
  // when the value is above it and to the lower one otherwise.
  function automatic logic signed [DataW-1:0] clamp_f(input logic signed [33:0] v,
                                                      input logic signed [DataW-1:0] lo,
                                                      input logic signed [DataW-1:0] hi);
    logic signed [33:0] lo_x;
    logic signed [33:0] hi_x;
    lo_x = {{2{lo[DataW-1]}}, lo};
    hi_x = {{2{hi[DataW-1]}}, hi};
    if (v > hi_x) begin
      clamp_f = hi;
    end else if (v < lo_x) begin
      clamp_f = lo;
    end else begin
      clamp_f = v[DataW-1:0];
    end
  endfunction

endpackage

### rtl/core/pcfd_in_if.sv
interface pcfd_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] target;
  logic signed [15:0] sample;

  modport source (output valid, output target, output sample, input ready);
  modport sink (input valid, input target, input sample, output ready);
endinterface

### rtl/core/pcfd_out_if.sv
interface pcfd_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

### rtl/core/pcfd_cfg_regs.sv
module pcfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcfd_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [pcfd_pkg::DataW-1:0]    cfg_data_i,
  output pcfd_pkg::cfg_t                cfg_o
);

  pcfd_pkg::cfg_t cfg_q;
  pcfd_pkg::cfg_t cfg_d;

  // Write decode: one register per write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pcfd_pkg::reg_idx_e'(cfg_idx_i))
        pcfd_pkg::RegPropGain:  cfg_d.prop_gain  = cfg_data_i;
        pcfd_pkg::RegIntegGain: cfg_d.integ_gain = cfg_data_i;
        pcfd_pkg::RegDerivGain: cfg_d.deriv_gain = cfg_data_i;
        pcfd_pkg::RegDerivPole: cfg_d.deriv_pole = cfg_data_i;
        pcfd_pkg::RegOutMin:    cfg_d.out_min    = cfg_data_i;
        pcfd_pkg::RegOutMax:    cfg_d.out_max    = cfg_data_i;
        pcfd_pkg::RegIntegMin:  cfg_d.integ_min  = cfg_data_i;
        pcfd_pkg::RegIntegMax:  cfg_d.integ_max  = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= '0;
      cfg_q.integ_gain <= '0;
      cfg_q.deriv_gain <= '0;
      cfg_q.deriv_pole <= '0;
      cfg_q.out_min    <= pcfd_pkg::DataMin;
      cfg_q.out_max    <= pcfd_pkg::DataMax;
      cfg_q.integ_min  <= pcfd_pkg::DataMin;
      cfg_q.integ_max  <= pcfd_pkg::DataMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/pcfd_front.sv
module pcfd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcfd_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  input  logic signed [pcfd_pkg::SmpW-1:0]  target_i,
  input  logic signed [pcfd_pkg::SmpW-1:0]  sample_i,
  output logic                              in_ready_o,
  output logic                              prod_valid_o,
  output pcfd_pkg::prod_t                   prod_o,
  input  logic                              prod_ready_i
);

  // Input stage: differences and the previous-sample state.
  logic                                   v0_q;
  logic signed [pcfd_pkg::ErrW-1:0]       err_q;
  logic signed [pcfd_pkg::ESumW-1:0]      esum_q;
  logic signed [pcfd_pkg::ErrW-1:0]       dm_q;
  logic signed [pcfd_pkg::ErrW-1:0]       last_err_q;
  logic signed [pcfd_pkg::SmpW-1:0]       last_smp_q;
  logic signed [pcfd_pkg::ErrW-1:0]       err_d;
  logic signed [pcfd_pkg::ESumW-1:0]      esum_d;
  logic signed [pcfd_pkg::ErrW-1:0]       dm_d;

  // Multiply stage.
  logic                                   v1_q;
  pcfd_pkg::prod_t                        prod_q;
  pcfd_pkg::prod_t                        prod_d;
  logic signed [48:0]                     prop_mul;
  logic signed [49:0]                     prop_rnd;
  logic signed [49:0]                     iterm_mul;
  logic signed [50:0]                     iterm_rnd;

  logic ready0;
  logic ready1;
  logic accept;

  assign ready1     = !v1_q || prod_ready_i;
  assign ready0     = !v0_q || ready1;
  assign accept     = in_valid_i && ready0;
  assign in_ready_o = ready0;

  // Error, trapezoid sum and measurement difference.
  always_comb begin
    err_d  = 17'(target_i) - 17'(sample_i);
    esum_d = 18'(err_d) + 18'(last_err_q);
    dm_d   = 17'(sample_i) - 17'(last_smp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      last_err_q <= '0;
      last_smp_q <= '0;
    end else begin
      if (ready0) begin
        v0_q <= in_valid_i;
      end
      if (accept) begin
        last_err_q <= err_d;
        last_smp_q <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q  <= err_d;
      esum_q <= esum_d;
      dm_q   <= dm_d;
    end
  end

  // P and I products rounded to nearest (ties up) to Q16.16, saturated.
  always_comb begin
    prop_mul    = 49'(cfg_i.prop_gain) * 49'(err_q);
    prop_rnd    = (50'(prop_mul) + 50'sd128) >>> 8;
    iterm_mul   = 50'(cfg_i.integ_gain) * 50'(esum_q);
    iterm_rnd   = (51'(iterm_mul) + 51'sd128) >>> 8;
    prod_d.prop  = pcfd_pkg::sat32_f(66'(prop_rnd));
    prod_d.iterm = pcfd_pkg::sat32_f(66'(iterm_rnd));
    prod_d.dprod = 49'(cfg_i.deriv_gain) * 49'(dm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && v0_q) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = v1_q;
  assign prod_o       = prod_q;

endmodule

### rtl/core/pcfd_loop.sv
module pcfd_loop (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcfd_pkg::cfg_t   cfg_i,
  input  logic             prod_valid_i,
  input  pcfd_pkg::prod_t  prod_i,
  output logic             prod_ready_o,
  output logic             terms_valid_o,
  output pcfd_pkg::terms_t terms_o,
  input  logic             terms_ready_i
);

  logic                               v2_q;
  logic signed [pcfd_pkg::DataW-1:0]  prop_q;
  logic signed [pcfd_pkg::DataW-1:0]  integ_acc_q;
  logic signed [pcfd_pkg::DataW-1:0]  integ_acc_d;
  logic signed [pcfd_pkg::DataW-1:0]  deriv_acc_q;
  logic signed [pcfd_pkg::DataW-1:0]  deriv_acc_d;
  logic signed [32:0]                 integ_sum;
  logic signed [pcfd_pkg::DataW-1:0]  integ_sat;
  logic signed [63:0]                 pole_mul;
  logic signed [65:0]                 dsum;
  logic signed [65:0]                 dsum_rnd;
  logic                               ready2;
  logic                               step;

  assign ready2       = !v2_q || terms_ready_i;
  assign step         = prod_valid_i && ready2;
  assign prod_ready_o = ready2;

  // Trapezoidal integrator: saturating add, then anti-windup clamp.
  always_comb begin
    integ_sum   = 33'(integ_acc_q) + 33'(prod_i.iterm);
    integ_sat   = pcfd_pkg::sat32_f(66'(integ_sum));
    integ_acc_d = pcfd_pkg::clamp_f(34'(integ_sat), cfg_i.integ_min, cfg_i.integ_max);
  end

  // Band-limited derivative on the measurement, 32 fraction bits inside.
  always_comb begin
    pole_mul    = 64'(cfg_i.deriv_pole) * 64'(deriv_acc_q);
    dsum        = 66'(pole_mul) - (66'(prod_i.dprod) <<< 8);
    dsum_rnd    = (dsum + 66'sd32768) >>> 16;
    deriv_acc_d = pcfd_pkg::sat32_f(dsum_rnd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      integ_acc_q <= '0;
      deriv_acc_q <= '0;
    end else begin
      if (ready2) begin
        v2_q <= prod_valid_i;
      end
      if (step) begin
        integ_acc_q <= integ_acc_d;
        deriv_acc_q <= deriv_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      prop_q <= prod_i.prop;
    end
  end

  assign terms_valid_o = v2_q;
  assign terms_o.prop  = prop_q;
  assign terms_o.integ = integ_acc_q;
  assign terms_o.deriv = deriv_acc_q;

endmodule

### rtl/core/pcfd_out.sv
module pcfd_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pcfd_pkg::cfg_t                     cfg_i,
  input  logic                               terms_valid_i,
  input  pcfd_pkg::terms_t                   terms_i,
  output logic                               terms_ready_o,
  output logic                               out_valid_o,
  output logic signed [pcfd_pkg::DataW-1:0]  drive_o,
  input  logic                               out_ready_i
);

  logic                               vo_q;
  logic signed [pcfd_pkg::DataW-1:0]  drive_q;
  logic signed [pcfd_pkg::DataW-1:0]  drive_d;
  logic signed [33:0]                 total;
  logic                               ready3;

  assign ready3        = !vo_q || out_ready_i;
  assign terms_ready_o = ready3;

  // Sum of the three terms, clamped to the output limits.
  always_comb begin
    total   = 34'(terms_i.prop) + 34'(terms_i.integ) + 34'(terms_i.deriv);
    drive_d = pcfd_pkg::clamp_f(total, cfg_i.out_min, cfg_i.out_max);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ready3) begin
      vo_q <= terms_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && terms_valid_i) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = vo_q;
  assign drive_o     = drive_q;

endmodule

### rtl/core/pid_controller_filtered_derivative_top.sv
// Each accepted input passes the input, multiply, state-update and output registers.
// Throughput: one transaction per cycle; each stage holds when its successor is stalled.
// The clock is set by the derivative filter state update: a 32x32 multiply, subtract and
// round in one combinational path, so the next sample sees the new state.
// Reset is asynchronous, active low; it clears all controller state, the stage valid
// bits and restores every configuration register to its reset value.
module pid_controller_filtered_derivative_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pcfd_in_if.sink                        in_i,
  pcfd_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [pcfd_pkg::IdxW-1:0]      cfg_idx_i,
  input  logic [pcfd_pkg::DataW-1:0]     cfg_data_i
);

  pcfd_pkg::cfg_t    cfg;
  pcfd_pkg::prod_t   prod;
  pcfd_pkg::terms_t  terms;
  logic              prod_valid;
  logic              prod_ready;
  logic              terms_valid;
  logic              terms_ready;

  // Configuration register file.
  pcfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register and gain products.
  pcfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_i.valid),
    .target_i     (in_i.target),
    .sample_i     (in_i.sample),
    .in_ready_o   (in_i.ready),
    .prod_valid_o (prod_valid),
    .prod_o       (prod),
    .prod_ready_i (prod_ready)
  );

  // Integrator and derivative filter state.
  pcfd_loop u_loop (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .prod_valid_i  (prod_valid),
    .prod_i        (prod),
    .prod_ready_o  (prod_ready),
    .terms_valid_o (terms_valid),
    .terms_o       (terms),
    .terms_ready_i (terms_ready)
  );

  // Output sum, clamp and result register.
  pcfd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .terms_valid_i (terms_valid),
    .terms_i       (terms),
    .terms_ready_o (terms_ready),
    .out_valid_o   (out_o.valid),
    .drive_o       (out_o.drive),
    .out_ready_i   (out_o.ready)
  );

endmodule

### rtl/core/pcfd_checker.sv
module pcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] drive_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i))
    else $error("stalled result changed or dropped");

  // With the output register empty, nothing can block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register empty");

  // An accepted transaction reaches the output when the sink keeps up.
  // The sink must be ready at each edge that moves it down the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i)
    else $error("result did not appear after three cycles");

  // No result is offered while in reset.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind pid_controller_filtered_derivative_top pcfd_checker u_pcfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive)
);

### bench/tb_pid_controller_filtered_derivative_top.sv
module tb_pid_controller_filtered_derivative_top;

  localparam int unsigned Latency      = 3;
  localparam int unsigned SettleCycles = Latency + 4;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned StallLimit   = 5000;
  localparam longint      WordMax      = 64'sd2147483647;
  localparam longint      WordMin      = -64'sd2147483648;

  // Kinds of register settings applied between bursts of traffic.
  typedef enum int {
    CfgUnity,
    CfgTie,
    CfgTypical,
    CfgRandom,
    CfgSatHigh,
    CfgSatLow,
    CfgTight,
    CfgCrossed
  } cfg_kind_e;

  // Flow-control patterns on the two channels.
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // Tracks controller state and the queue of drive values still owed by the block.
  class drive_scoreboard;
    pcfd_pkg::cfg_t     regs;
    logic signed [31:0] integ_acc;
    logic signed [31:0] deriv_acc;
    logic signed [16:0] prev_err;
    logic signed [15:0] prev_smp;
    logic signed [31:0] drive_q[$];
    int unsigned        failures;

    function new();
      regs.prop_gain  = '0;
      regs.integ_gain = '0;
      regs.deriv_gain = '0;
      regs.deriv_pole = '0;
      regs.out_min    = pcfd_pkg::DataMin;
      regs.out_max    = pcfd_pkg::DataMax;
      regs.integ_min  = pcfd_pkg::DataMin;
      regs.integ_max  = pcfd_pkg::DataMax;
      integ_acc       = '0;
      deriv_acc       = '0;
      prev_err        = '0;
      prev_smp        = '0;
      failures        = 0;
    endfunction

    function void set_reg(pcfd_pkg::reg_idx_e idx, logic signed [31:0] v);
      case (idx)
        pcfd_pkg::RegPropGain:  regs.prop_gain  = v;
        pcfd_pkg::RegIntegGain: regs.integ_gain = v;
        pcfd_pkg::RegDerivGain: regs.deriv_gain = v;
        pcfd_pkg::RegDerivPole: regs.deriv_pole = v;
        pcfd_pkg::RegOutMin:    regs.out_min    = v;
        pcfd_pkg::RegOutMax:    regs.out_max    = v;
        pcfd_pkg::RegIntegMin:  regs.integ_min  = v;
        pcfd_pkg::RegIntegMax:  regs.integ_max  = v;
        default: ;
      endcase
    endfunction

    static function longint wide(logic signed [31:0] v);
      return v;
    endfunction

    // Divide by 2^s, rounding to nearest with ties toward plus infinity.
    static function longint round_shift(longint v, int unsigned s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint sat_word(longint v);
      if (v > WordMax) return WordMax;
      if (v < WordMin) return WordMin;
      return v;
    endfunction

    // Upper limit tested first, so crossed limits give the upper one only above it.
    static function longint clamp_word(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // Advance the controller by one accepted input transaction.
    function void note_input(logic signed [15:0] tgt, logic signed [15:0] smp);
      longint err;
      longint prop;
      longint iterm;
      longint acc;
      longint dm;
      longint dsum;
      longint drv;
      err   = longint'(tgt) - longint'(smp);
      prop  = sat_word(round_shift(wide(regs.prop_gain) * err, 8));
      iterm = sat_word(round_shift(wide(regs.integ_gain) * (err + longint'(prev_err)), 8));
      acc   = sat_word(wide(integ_acc) + iterm);
      acc   = clamp_word(acc, wide(regs.integ_min), wide(regs.integ_max));
      integ_acc = acc[31:0];
      // Band-limited derivative on the measurement, 32 fraction bits before rounding.
      dm   = longint'(smp) - longint'(prev_smp);
      dsum = wide(regs.deriv_pole) * wide(deriv_acc) - wide(regs.deriv_gain) * dm * 256;
      acc  = sat_word(round_shift(dsum, 16));
      deriv_acc = acc[31:0];
      drv = clamp_word(prop + wide(integ_acc) + wide(deriv_acc),
                       wide(regs.out_min), wide(regs.out_max));
      prev_err = err[16:0];
      prev_smp = smp;
      drive_q.push_back(drv[31:0]);
    endfunction

    // Compare one output transaction with the oldest outstanding drive value.
    function void check_result(logic signed [31:0] got);
      logic signed [31:0] want;
      if (drive_q.size() == 0) begin
        $error("drive result %0d arrived with no transaction outstanding", got);
        failures++;
        return;
      end
      want = drive_q.pop_front();
      if (got !== want) begin
        $error("drive mismatch: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pcfd_pkg::IdxW-1:0]     cfg_idx;
  logic [pcfd_pkg::DataW-1:0]    cfg_data;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  logic signed [15:0]  walk_tgt       = '0;
  logic signed [15:0]  walk_smp       = '0;
  drive_scoreboard     sb             = new();

  pcfd_in_if  in_if ();
  pcfd_out_if out_if ();

  pid_controller_filtered_derivative_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random backpressure on the result channel.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transaction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.drive);
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_mag(int unsigned mag);
    logic signed [31:0] v;
    v = $urandom_range(mag);
    if ($urandom_range(1) != 0) begin
      v = -v;
    end
    return v;
  endfunction

  // Next value of a Q8.8 field: often a slow walk, with jumps, extremes and noise.
  function automatic logic signed [15:0] pick_q88(logic signed [15:0] near);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      1, 2, 3: return 16'($urandom);
      4, 5:    return 16'(int'($urandom_range(512)) - 256);
      default: return 16'(int'(near) + int'($urandom_range(64)) - 32);
    endcase
  endfunction

  function automatic void make_config(input cfg_kind_e kind,
                                      output logic signed [31:0] vals [8]);
    logic signed [31:0] a;
    logic signed [31:0] b;
    vals[pcfd_pkg::RegPropGain]  = rand_mag(32'h0004_0000);
    vals[pcfd_pkg::RegIntegGain] = rand_mag(32'h0000_1000);
    vals[pcfd_pkg::RegDerivGain] = rand_mag(32'h0004_0000);
    vals[pcfd_pkg::RegDerivPole] = $urandom_range(32'h0001_0000);
    vals[pcfd_pkg::RegOutMin]    = pcfd_pkg::DataMin;
    vals[pcfd_pkg::RegOutMax]    = pcfd_pkg::DataMax;
    vals[pcfd_pkg::RegIntegMin]  = pcfd_pkg::DataMin;
    vals[pcfd_pkg::RegIntegMax]  = pcfd_pkg::DataMax;
    case (kind)
      CfgUnity: begin
        vals[pcfd_pkg::RegPropGain]  = 32'sh0001_0000;
        vals[pcfd_pkg::RegIntegGain] = 32'sh0000_8000;
        vals[pcfd_pkg::RegDerivGain] = 32'sh0002_0000;
        vals[pcfd_pkg::RegDerivPole] = 32'sh0000_e666;
      end
      CfgTie: begin
        // Unit raw gains put products exactly on half-way points.
        vals[pcfd_pkg::RegPropGain]  = 32'sd1;
        vals[pcfd_pkg::RegIntegGain] = 32'sd1;
        vals[pcfd_pkg::RegDerivGain] = 32'sd1;
        vals[pcfd_pkg::RegDerivPole] = 32'sh0000_8000;
      end
      CfgTypical: begin
        vals[pcfd_pkg::RegOutMin]   = -$signed(32'($urandom_range(32'h4000_0000)));
        vals[pcfd_pkg::RegOutMax]   = $urandom_range(32'h4000_0000);
        vals[pcfd_pkg::RegIntegMin] = -$signed(32'($urandom_range(32'h4000_0000)));
        vals[pcfd_pkg::RegIntegMax] = $urandom_range(32'h4000_0000);
      end
      CfgRandom: begin
        foreach (vals[i]) begin
          vals[i] = $urandom;
        end
      end
      CfgSatHigh: begin
        vals[pcfd_pkg::RegPropGain]  = pcfd_pkg::DataMax;
        vals[pcfd_pkg::RegIntegGain] = pcfd_pkg::DataMax;
        vals[pcfd_pkg::RegDerivGain] = pcfd_pkg::DataMax;
        vals[pcfd_pkg::RegDerivPole] = pcfd_pkg::DataMax;
      end
      CfgSatLow: begin
        vals[pcfd_pkg::RegPropGain]  = pcfd_pkg::DataMin;
        vals[pcfd_pkg::RegIntegGain] = pcfd_pkg::DataMin;
        vals[pcfd_pkg::RegDerivGain] = pcfd_pkg::DataMin;
        vals[pcfd_pkg::RegDerivPole] = pcfd_pkg::DataMin;
      end
      CfgTight: begin
        vals[pcfd_pkg::RegPropGain] = rand_mag(32'h0100_0000);
        vals[pcfd_pkg::RegOutMin]   = -$signed(32'($urandom_range(32'h0004_0000)));
        vals[pcfd_pkg::RegOutMax]   = $urandom_range(32'h0004_0000);
        vals[pcfd_pkg::RegIntegMin] = -$signed(32'($urandom_range(32'h0002_0000)));
        vals[pcfd_pkg::RegIntegMax] = $urandom_range(32'h0002_0000);
      end
      CfgCrossed: begin
        // Lower limits above upper limits on both clamps.
        a = $urandom_range(32'h0010_0000);
        b = $urandom_range(32'h0010_0000);
        vals[pcfd_pkg::RegOutMin]   = a + 1;
        vals[pcfd_pkg::RegOutMax]   = -a;
        vals[pcfd_pkg::RegIntegMin] = b + 1;
        vals[pcfd_pkg::RegIntegMax] = -b;
      end
      default: ;
    endcase
  endfunction

  // Write all eight registers on consecutive cycles while the block is idle.
  task automatic load_config(input cfg_kind_e kind);
    logic signed [31:0]  vals [8];
    pcfd_pkg::reg_idx_e  idx;
    make_config(kind, vals);
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= vals[idx];
      sb.set_reg(idx, vals[idx]);
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IdleSender)   ? 60 : (mode == IdleBoth) ? 31 : 0;
    recv_stall_pct = (mode == IdleReceiver) ? 60 : (mode == IdleBoth) ? 31 : 0;
  endtask

  // Offer one input transaction and record it once accepted.
  task automatic send_item(input logic signed [15:0] tgt, input logic signed [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.target <= tgt;
    in_if.sample <= smp;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    sb.note_input(tgt, smp);
  endtask

  // Drop valid and wait until every outstanding drive value has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  function automatic cfg_kind_e phase_kind(int unsigned p);
    case (p % 12)
      0, 6, 11: return CfgTypical;
      1, 7, 10: return CfgRandom;
      2:        return CfgSatHigh;
      3, 8:     return CfgTight;
      4:        return CfgSatLow;
      default:  return CfgCrossed;
    endcase
  endfunction

  // Main stimulus sequence.
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= pcfd_pkg::RegPropGain;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.target <= '0;
    in_if.sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all gains zero, so the drive stays at zero.
    set_idle(IdleNone);
    send_item(16'sh7fff, 16'sh8000);
    send_item(16'sh0000, 16'sh0000);
    drain();

    // Field extremes with unity-scale gains.
    load_config(CfgUnity);
    send_item(16'sh7fff, 16'sh8000);
    send_item(16'sh8000, 16'sh7fff);
    send_item(16'sh7fff, 16'sh7fff);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh0000, 16'sh0000);
    send_item(-16'sd1, 16'sh0000);
    send_item(16'sh0000, -16'sd1);
    send_item(16'sd256, 16'sh0000);
    send_item(-16'sd256, 16'sd256);
    send_item(16'sd100, -16'sd100);
    drain();

    // Rounding ties in both directions.
    load_config(CfgTie);
    send_item(16'sd128, 16'sh0000);
    send_item(-16'sd128, 16'sh0000);
    send_item(16'sd384, 16'sh0000);
    send_item(-16'sd384, 16'sh0000);
    send_item(16'sh0000, 16'sd128);
    send_item(16'sh0000, -16'sd128);
    send_item(16'sh0000, 16'sh0000);
    drain();
    repeat (SettleCycles) @(posedge clk);

    // Random bursts, each under its own settings and flow-control pattern.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      load_config(phase_kind(p));
      set_idle(idle_mode_e'(p % 4));
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if ((p % 5 == 2) && (n == PhaseItems / 2)) begin
          drain();
        end
        walk_tgt = pick_q88(walk_tgt);
        walk_smp = pick_q88(walk_smp);
        send_item(walk_tgt, walk_smp);
      end
      drain();
      repeat (SettleCycles) @(posedge clk);
    end

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### pid_controller_filtered_derivative_top.f
rtl/core/pcfd_pkg.sv
rtl/core/pcfd_in_if.sv
rtl/core/pcfd_out_if.sv
rtl/core/pcfd_cfg_regs.sv
rtl/core/pcfd_front.sv
rtl/core/pcfd_loop.sv
rtl/core/pcfd_out.sv
rtl/core/pid_controller_filtered_derivative_top.sv
rtl/core/pcfd_checker.sv
bench/tb_pid_controller_filtered_derivative_top.sv
